// ===== hw/rtl/aktr_pkg.sv =====
// ----------------------------------------------------------------------------
// aktr_pkg: shared types and constants
// Widths, request codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package aktr_pkg;

    localparam int ENTRIES      = 16;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int KEY_W        = 64;
    localparam int PAYLOAD_W    = 32;
    localparam int AGE_W        = 32;
    localparam int REFS_W       = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OLDEST,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic old_clr;
        logic old_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic need_evict;
        t_req req;
    } t_stat;

endpackage

// ===== hw/rtl/aktr_ctrl.sv =====
// ----------------------------------------------------------------------------
// aktr_ctrl: request sequencer
// Steps the datapath through the match scan, the oldest scan when an insert evicts, and the commit.
// ----------------------------------------------------------------------------
module aktr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  aktr_pkg::t_stat i_stat,
    output aktr_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    import aktr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_SCAN;
            ST_SCAN:   if (i_stat.last) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_stat.req == REQ_INSERT && i_stat.need_evict) n_state = ST_OLDEST;
                else n_state = ST_COMMIT;
            end
            ST_OLDEST: if (i_stat.last) n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
                o_cmd.scan_clr = i_start;
            end
            ST_SCAN:   o_cmd.scan_step = 1'b1;
            ST_DECIDE: o_cmd.old_clr = 1'b1;
            ST_OLDEST: o_cmd.old_step = 1'b1;
            ST_COMMIT: o_cmd.commit = 1'b1;
            ST_DONE:   o_done = 1'b1;
            default:   o_busy = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/aktr_datapath.sv =====
// ----------------------------------------------------------------------------
// aktr_datapath: entry store and scan logic
// Holds the table, scans one entry per cycle and applies the update.
// ----------------------------------------------------------------------------
module aktr_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  aktr_pkg::t_cmd                 i_cmd,
    input  logic                           i_report_en,
    input  logic [1:0]                     i_req_type,
    input  logic [aktr_pkg::KEY_W-1:0]     i_key,
    input  logic [aktr_pkg::PAYLOAD_W-1:0] i_payload,
    output aktr_pkg::t_stat                o_stat,
    output logic                           o_hit,
    output logic [3:0]                     o_slot,
    output logic                           o_evicted,
    output logic                           o_released,
    output logic [31:0]                    o_released_payload
);
    import aktr_pkg::*;

    logic [ENTRIES-1:0]   r_valid;
    logic [AGE_W-1:0]     r_age  [ENTRIES];
    logic [REFS_W-1:0]    r_refs [ENTRIES];
    logic [KEY_W-1:0]     r_key  [ENTRIES];
    logic [PAYLOAD_W-1:0] r_pl   [ENTRIES];

    t_req                 r_req;
    logic [KEY_W-1:0]     r_k;
    logic [PAYLOAD_W-1:0] r_p;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_found, r_vacant;
    logic [IDX_W-1:0]     r_fslot, r_vslot, r_oslot;
    logic [AGE_W-1:0]     r_max;

    logic match;
    logic [AGE_W-1:0] age_inc;

    assign match = r_valid[r_idx] && r_key[r_idx] == r_k;
    assign age_inc = (r_age[r_idx] == '1) ? r_age[r_idx] : r_age[r_idx] + 1'b1;
    assign o_stat.last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_stat.need_evict = !r_found && !r_vacant;
    assign o_stat.req = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
                r_refs[i] <= '1 >> (REFS_W - 1);
            end
            o_hit <= 1'b0;
            o_slot <= '0;
            o_evicted <= 1'b0;
            o_released <= 1'b0;
            o_released_payload <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req <= t_req'(i_req_type);
                r_k <= i_key;
                r_p <= i_payload;
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
                r_found <= 1'b0;
                r_vacant <= 1'b0;
                r_fslot <= '0;
                r_vslot <= '0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_req == REQ_INSERT) begin
                    r_age[r_idx] <= age_inc;
                    if (!r_found && !r_vacant && !r_valid[r_idx]) begin
                        r_vacant <= 1'b1;
                        r_vslot <= r_idx;
                    end
                    if (match) begin
                        r_age[r_idx] <= '0;
                        if (r_refs[r_idx] != '1) r_refs[r_idx] <= r_refs[r_idx] + 1'b1;
                    end
                end
                if (match && !r_found) begin
                    r_found <= 1'b1;
                    r_fslot <= r_idx;
                end
            end
            if (i_cmd.old_clr) begin
                r_idx <= '0;
                r_max <= '0;
                r_oslot <= IDX_W'(ENTRIES - 1);
            end
            if (i_cmd.old_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_age[r_idx] > r_max) begin
                    r_max <= r_age[r_idx];
                    r_oslot <= r_idx;
                end
                r_age[r_idx] <= age_inc;
            end
            o_hit <= 1'b0;
            o_slot <= '0;
            o_evicted <= 1'b0;
            o_released <= 1'b0;
            o_released_payload <= '0;
            if (i_cmd.commit) begin
                o_hit <= r_found && (r_req != REQ_NONE);
                o_slot <= 4'(r_fslot);
                case (r_req)
                    REQ_INSERT: begin
                        if (!r_found) begin
                            logic [IDX_W-1:0] s;
                            s = r_vacant ? r_vslot : r_oslot;
                            o_slot <= 4'(s);
                            if (!r_vacant) begin
                                o_evicted <= 1'b1;
                                o_released <= i_report_en;
                                o_released_payload <= i_report_en ? r_pl[s] : '0;
                            end
                            r_valid[s] <= 1'b1;
                            r_key[s] <= r_k;
                            r_age[s] <= '0;
                            r_refs[s] <= REFS_W'(1);
                            r_pl[s] <= r_p;
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_found && r_refs[r_fslot] <= REFS_W'(1)) begin
                            r_refs[r_fslot] <= '0;
                            r_valid[r_fslot] <= 1'b0;
                            o_released <= i_report_en;
                            o_released_payload <= i_report_en ? r_pl[r_fslot] : '0;
                        end else if (r_found) begin
                            r_refs[r_fslot] <= r_refs[r_fslot] - 1'b1;
                        end
                    end
                    REQ_NONE: o_slot <= '0;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/aged_key_table_with_refcount.sv =====
// ----------------------------------------------------------------------------
// aged_key_table_with_refcount: 16-entry keyed table with aging and refcounts
// Insert, remove and find over a fully associative store.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// request   in         start while busy low
// result    out        o_done strobe, one cycle
// config    in         i_cfg_valid and o_cfg_ready
//
// A request runs one match scan over the entries, one entry per cycle, plus a
// second scan for the oldest entry when an insert evicts.
// Reset clears valid marks and ages and sets counts to one. The result register is
// written on the commit cycle and shown for one cycle; there is no stall.
module aged_key_table_with_refcount (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key,
    input  logic [31:0] i_payload,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_done,
    output logic        o_hit,
    output logic [3:0]  o_slot,
    output logic        o_evicted,
    output logic        o_released,
    output logic [31:0] o_released_payload
);
    import aktr_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  r_report_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_report_en <= i_cfg_data;
        end
    end

    aktr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_stat(stat),
        .o_cmd(cmd), .o_busy(busy), .o_done
    );

    aktr_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_report_en(r_report_en),
        .i_req_type, .i_key, .i_payload, .o_stat(stat),
        .o_hit, .o_slot, .o_evicted, .o_released, .o_released_payload
    );

endmodule

// ===== hw/rtl/aktr_checker.sv =====
// ----------------------------------------------------------------------------
// aktr_checker: port-level properties
// Checks result strobes and flag consistency seen at the top level.
// ----------------------------------------------------------------------------
module aktr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_evicted,
    input logic        o_released,
    input logic        o_hit
);
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted request did not raise busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_evict_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_evicted |-> !o_hit) else $error("eviction reported with hit");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result shown while idle");
    a_flags_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> !o_hit && !o_evicted && !o_released)
        else $error("result flags raised without strobe");
endmodule

bind aged_key_table_with_refcount aktr_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_evicted, .o_released, .o_hit
);

// ===== sim/aktr_checker.sv =====
// ----------------------------------------------------------------------------
// aktr_scoreboard: result predictor and comparator for the keyed table
// Watches accepted requests and configuration writes, keeps its own copy of
// the table, and compares every result strobe with the oldest expectation.
// ----------------------------------------------------------------------------
module aktr_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key,
    input  logic [31:0] i_payload,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_done,
    input  logic        i_hit,
    input  logic [3:0]  i_slot,
    input  logic        i_evicted,
    input  logic        i_released,
    input  logic [31:0] i_released_payload,
    output int          o_errors,
    output int          o_pending
);
    import aktr_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        evicted;
        logic        released;
        logic [31:0] rel_pl;
    } t_outcome;

    t_outcome             outcome_q[$];
    logic                 report_en;
    logic                 tv[ENTRIES];
    logic [KEY_W-1:0]     tk[ENTRIES];
    logic [AGE_W-1:0]     ta[ENTRIES];
    logic [REFS_W-1:0]    tr[ENTRIES];
    logic [PAYLOAD_W-1:0] tp[ENTRIES];

    assign o_pending = outcome_q.size();

    function automatic void bump_age(int i);
        if (ta[i] != '1) ta[i] = ta[i] + 1;
    endfunction

    function automatic t_outcome table_apply(t_req req, logic [63:0] k, logic [31:0] pl);
        t_outcome o;
        bit found, vacant;
        int vac, slot;
        logic [AGE_W-1:0] mx;
        o = '0; found = 0; vacant = 0; vac = 0; slot = 0;
        if (req == REQ_INSERT) begin
            for (int i = 0; i < ENTRIES; i++) begin
                bump_age(i);
                if (!found && !vacant && !tv[i]) begin
                    vacant = 1; vac = i;
                end
                if (tv[i] && tk[i] == k) begin
                    if (!found) slot = i;
                    found = 1;
                    if (tr[i] != '1) tr[i] = tr[i] + 1;
                    ta[i] = 0;
                end
            end
            if (found) begin
                o.hit = 1;
            end else begin
                if (vacant) begin
                    slot = vac;
                end else begin
                    mx = 0; slot = ENTRIES - 1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ta[i] > mx) begin
                            mx = ta[i]; slot = i;
                        end
                        bump_age(i);
                    end
                    o.evicted = 1;
                    if (report_en) begin
                        o.released = 1; o.rel_pl = tp[slot];
                    end
                end
                tv[slot] = 1; tk[slot] = k; ta[slot] = 0; tr[slot] = 1; tp[slot] = pl;
            end
        end else if (req == REQ_REMOVE || req == REQ_FIND) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && tv[i] && tk[i] == k) begin
                    found = 1; slot = i;
                end
            end
            if (found) begin
                o.hit = 1;
                if (req == REQ_REMOVE) begin
                    if (tr[slot] != 0) tr[slot] = tr[slot] - 1;
                    if (tr[slot] == 0) begin
                        tv[slot] = 0;
                        if (report_en) begin
                            o.released = 1; o.rel_pl = tp[slot];
                        end
                    end
                end
            end
        end
        o.slot = slot[3:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            report_en <= 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
                tv[i] = 0; ta[i] = 0; tr[i] = 1; tk[i] = 0; tp[i] = 0;
            end
            outcome_q.delete();
            o_errors <= 0;
        end else begin
            if (i_done) begin
                got = '{i_hit, i_slot, i_evicted, i_released, i_released_payload};
                if (outcome_q.size() == 0) begin
                    if (o_errors < 10) $display("Unexpected result %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) begin
                            $display("Mismatch: expected hit=%b slot=%0d ev=%b rel=%b pl=%h",
                                     want.hit, want.slot, want.evicted, want.released,
                                     want.rel_pl);
                            $display("          actual   hit=%b slot=%0d ev=%b rel=%b pl=%h",
                                     got.hit, got.slot, got.evicted, got.released,
                                     got.rel_pl);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                outcome_q.push_back(table_apply(t_req'(i_req_type), i_key, i_payload));
            if (i_cfg_valid && i_cfg_ready) report_en <= i_cfg_data;
        end
    end

endmodule

// ===== sim/tb_aged_key_table_with_refcount.sv =====
// ----------------------------------------------------------------------------
// tb_aged_key_table_with_refcount: testbench for the aged keyed table
// Drives directed and random insert, remove, find and no-op requests, mostly over
// a small key pool, switches release reporting between phases, and takes its
// verdict from the scoreboard.
// ----------------------------------------------------------------------------
module tb_aged_key_table_with_refcount;
    import aktr_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_req_type = 0;
    logic [63:0] i_key = 0;
    logic [31:0] i_payload = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 0;
    logic        o_done, o_hit, o_evicted, o_released;
    logic [3:0]  o_slot;
    logic [31:0] o_released_payload;
    int          errors, pending, idle_cycles;
    bit          calm;
    logic [63:0] key_pool[24];

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    aged_key_table_with_refcount dut (.*);

    aktr_scoreboard chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_req_type, .i_key,
        .i_payload, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_done(o_done), .i_hit(o_hit), .i_slot(o_slot), .i_evicted(o_evicted),
        .i_released(o_released), .i_released_payload(o_released_payload),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(t_req req, logic [63:0] k, logic [31:0] pl);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 10) @(negedge i_clk);
        start <= 1; i_req_type <= req; i_key <= k; i_payload <= pl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 0;
        i_req_type <= $urandom; i_key <= {$urandom, $urandom}; i_payload <= $urandom;
    endtask

    task automatic write_report_enable(logic v);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_phase(int n);
        int r;
        logic [63:0] k;
        for (int j = 0; j < n; j++) begin
            calm = (j >= n / 3 && j < n / 2);
            r = $urandom_range(0, 99);
            k = (r < 90) ? key_pool[$urandom_range(0, 23)] : {$urandom, $urandom};
            r = $urandom_range(0, 99);
            send_request(r < 45 ? REQ_INSERT : r < 75 ? REQ_REMOVE :
                         r < 97 ? REQ_FIND : REQ_NONE, k, $urandom);
        end
        calm = 0;
    endtask

    initial begin
        for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_request(REQ_FIND, '0, '0);
        send_request(REQ_REMOVE, '1, '1);
        send_request(REQ_INSERT, '0, '1);
        send_request(REQ_INSERT, '0, 32'h0);
        send_request(REQ_INSERT, '1, 32'hA5A5_5A5A);
        send_request(REQ_FIND, '1, '0);
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_NONE, '1, '1);
        for (int i = 2; i < 20; i++) send_request(REQ_INSERT, key_pool[i], $urandom);
        random_phase(500);
        write_report_enable(0);
        random_phase(550);
        write_report_enable(1);
        random_phase(550);
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
